### sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/ragr_pkg.sv
// types and constants for the rational alu with gcd reduction
package ragr_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 32;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_MUL   = 3'd2,
        KIND_DIV   = 3'd3,
        KIND_SCALE = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] first_numerator;
        logic signed [15:0] first_denominator;
        logic signed [15:0] second_numerator;
        logic signed [15:0] second_denominator;
        logic signed [15:0] scale_factor;
    } request_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_numerator;
        logic signed [DEN_W-1:0] result_denominator;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GCD_CHK,
        ST_GCD_DIV,
        ST_QN_INIT,
        ST_QN_DIV,
        ST_QD_INIT,
        ST_QD_DIV,
        ST_DONE
    } state_t;

endpackage

### sv/ragr_divider.sv
// restoring divider, one quotient bit per cycle
module ragr_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

### sv/rational_alu_gcd_reduce.sv
// top level of the rational alu with gcd reduction
//  channel | signals              | direction
//  request | start, busy, request | in
//  result  | valid, result        | out
// PW = 2*OPERAND_WIDTH+2 is the width of the one shared bit serial divider
// after acceptance: products and sum (MUL0, MUL1, MUL2, SUM), a check that loads the gcd operands,
// one divider run per gcd remainder step (euclid, data dependent), a final check,
// and two exact divisions by the gcd; the result strobe follows
// an unused selector skips the gcd and gives its strobe after the products and sum
// busy is high from acceptance until the result strobe; results cannot stall
// reset clears the sequencer only
`include "assert_macros.svh"
module rational_alu_gcd_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ragr_pkg::request_t  request,
    output logic                valid,
    output ragr_pkg::result_t   result
);

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW + 2;
    localparam int SW = (PW > ragr_pkg::NUM_W) ? PW : ragr_pkg::NUM_W;

    ragr_pkg::state_t state_reg, state_next;
    ragr_pkg::request_t req_reg, req_next;
    logic signed [OW-1:0] n1, d1, n2, d2, sf;
    logic signed [OW-1:0] ma, mb;
    logic signed [2*OW-1:0] prod;
    logic signed [PW-1:0] p0_reg, p0_next, num_reg, num_next, den_reg, den_next;
    logic [PW-1:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [PW-1:0] qn_reg, qn_next;
    logic valid_reg, valid_next;
    ragr_pkg::result_t res_reg, res_next;
    logic bad_reg, bad_next;
    logic dv_start, dv_done;
    logic [PW-1:0] dv_a, dv_b, dv_q, dv_r;
    logic [PW-1:0] mag_num, mag_den;
    logic signed [SW-1:0] sq;

    assign n1 = OW'($unsigned(req_reg.first_numerator));
    assign d1 = OW'($unsigned(req_reg.first_denominator));
    assign n2 = OW'($unsigned(req_reg.second_numerator));
    assign d2 = OW'($unsigned(req_reg.second_denominator));
    assign sf = OW'($unsigned(req_reg.scale_factor));
    assign prod = ma * mb;
    assign mag_num = num_reg[PW-1] ? PW'(-num_reg) : PW'(num_reg);
    assign mag_den = den_reg[PW-1] ? PW'(-den_reg) : PW'(den_reg);

    ragr_divider #(.W(PW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(dv_b), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ragr_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        p0_reg  <= p0_next;
        num_reg <= num_next;
        den_reg <= den_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        g_reg   <= g_next;
        qn_reg  <= qn_next;
        res_reg <= res_next;
        bad_reg <= bad_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        p0_next    = p0_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        qn_next    = qn_reg;
        res_next   = res_reg;
        bad_next   = bad_reg;
        valid_next = 1'b0;
        dv_start   = 1'b0;
        dv_a       = x_reg;
        dv_b       = y_reg;
        ma         = n1;
        mb         = d2;
        sq         = '0;
        unique case (state_reg)
            ragr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    bad_next   = request.kind > 3'(ragr_pkg::KIND_SCALE);
                    state_next = ragr_pkg::ST_MUL0;
                end
            end
            ragr_pkg::ST_MUL0:
            begin
                unique case (req_reg.kind)
                    3'(ragr_pkg::KIND_MUL): mb = n2;
                    3'(ragr_pkg::KIND_SCALE): mb = sf;
                    default: mb = d2;
                endcase
                p0_next    = PW'(prod);
                state_next = ragr_pkg::ST_MUL1;
            end
            ragr_pkg::ST_MUL1:
            begin
                ma = n2;
                mb = d1;
                num_next   = PW'(prod);
                state_next = ragr_pkg::ST_MUL2;
            end
            ragr_pkg::ST_MUL2:
            begin
                ma = d1;
                mb = (req_reg.kind == 3'(ragr_pkg::KIND_DIV)) ? n2 : d2;
                den_next = (req_reg.kind == 3'(ragr_pkg::KIND_SCALE))
                           ? PW'(d1) : PW'(prod);
                state_next = ragr_pkg::ST_SUM;
            end
            ragr_pkg::ST_SUM:
            begin
                case (req_reg.kind)
                    3'(ragr_pkg::KIND_ADD): num_next = p0_reg + num_reg;
                    3'(ragr_pkg::KIND_SUB): num_next = p0_reg - num_reg;
                    default: num_next = p0_reg;
                endcase
                state_next = ragr_pkg::ST_GCD_CHK;
                x_next = '0;
                y_next = '0;
                if (bad_reg)
                begin
                    res_next.result_numerator   = '0;
                    res_next.result_denominator = 32'sd1;
                    valid_next = 1'b1;
                    state_next = ragr_pkg::ST_IDLE;
                end
            end
            ragr_pkg::ST_GCD_CHK:
            begin
                if (x_reg == '0 && y_reg == '0)
                begin
                    x_next = mag_num;
                    y_next = mag_den;
                    if (mag_num == '0 && mag_den == '0)
                    begin
                        g_next     = PW'(1);
                        state_next = ragr_pkg::ST_QN_INIT;
                    end
                end
                else if (y_reg == '0)
                begin
                    g_next     = x_reg;
                    state_next = ragr_pkg::ST_QN_INIT;
                end
                else
                begin
                    dv_start   = 1'b1;
                    state_next = ragr_pkg::ST_GCD_DIV;
                end
            end
            ragr_pkg::ST_GCD_DIV:
            begin
                if (dv_done)
                begin
                    x_next     = y_reg;
                    y_next     = dv_r;
                    state_next = ragr_pkg::ST_GCD_CHK;
                end
            end
            ragr_pkg::ST_QN_INIT:
            begin
                dv_start   = 1'b1;
                dv_a       = mag_num;
                dv_b       = g_reg;
                state_next = ragr_pkg::ST_QN_DIV;
            end
            ragr_pkg::ST_QN_DIV:
            begin
                if (dv_done)
                begin
                    qn_next    = dv_q;
                    state_next = ragr_pkg::ST_QD_INIT;
                end
            end
            ragr_pkg::ST_QD_INIT:
            begin
                dv_start   = 1'b1;
                dv_a       = mag_den;
                dv_b       = g_reg;
                state_next = ragr_pkg::ST_QD_DIV;
            end
            ragr_pkg::ST_QD_DIV:
            begin
                if (dv_done)
                begin
                    sq = SW'(qn_reg);
                    if (num_reg[PW-1])
                        sq = -sq;
                    res_next.result_numerator = sq[ragr_pkg::NUM_W-1:0];
                    sq = SW'(dv_q);
                    if (den_reg[PW-1])
                        sq = -sq;
                    res_next.result_denominator = sq[ragr_pkg::DEN_W-1:0];
                    valid_next = 1'b1;
                    state_next = ragr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ragr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ragr_pkg::ST_IDLE);
    assign valid  = valid_reg;
    assign result = res_reg;

    `ASSERT_CLK(a_valid_pulse, clk, rst_n, valid |=> !valid, "strobe longer than a cycle")
    `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
    `ASSERT_NEVER(a_valid_idle, clk, rst_n, valid && busy, "result strobe while busy")

endmodule
